[rtl/core/hashed_block_buffer_cache_macros.svh]
// Assertion macros shared by the buffer cache RTL.
`ifndef HASHED_BLOCK_BUFFER_CACHE_MACROS_SVH
`define HASHED_BLOCK_BUFFER_CACHE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HBC_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define HBC_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[rtl/core/hbc_pkg.sv]
package hbc_pkg;

  localparam int unsigned CmdW = 2;
  localparam int unsigned DevW = 8;
  localparam int unsigned BlkW = 31;
  localparam int unsigned IdxW = 5;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW = 8;
  localparam int unsigned BktW = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_GET   = 2'd0,
    CMD_REL   = 2'd1,
    CMD_PIN   = 2'd2,
    CMD_UNPIN = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [DevW-1:0]  device;
    logic [BlkW-1:0]  block_number;
    logic [IdxW-1:0]  buffer_index;
    logic [TimeW-1:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] granted_buffer;
    logic            was_hit;
    logic            needs_read;
    logic            status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIT_SCAN,
    ST_HIT_DONE,
    ST_VIC_SCAN,
    ST_VIC_DONE,
    ST_SIMPLE,
    ST_RESULT
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;       // capture the transaction, clear the scan
    logic scan_hit;   // examine the buffer under the scan pointer for a tag hit
    logic scan_vic;   // examine the buffer under the scan pointer as a victim
    logic next_bkt;   // move the victim search to the following bucket
    logic do_hit;     // commit a hit
    logic do_vic;     // commit a victim retag
    logic do_fail;    // report no free buffer
    logic do_simple;  // release, pin or unpin
    logic emit;       // present the result
  } ctl_cmd_t;

  typedef struct packed {
    logic is_get;
    logic scan_last;
    logic hit_found;
    logic vic_found;
    logic last_bkt;
  } ctl_sts_t;

endpackage

[rtl/core/hashed_block_buffer_cache.sv]
// Hashed block buffer cache. A transaction is taken when start is high and
// busy is low; one result per transaction appears on out_item for one cycle
// with out_valid, and the receiver cannot stall it. A get is loaded, makes
// one scan pass over all BUFFER_COUNT buffers for a tag hit, and on a miss
// one further pass per bucket searched for a victim (home bucket first), up
// to BUCKET_COUNT buckets, each pass followed by a decision state, then a
// result state. Release, pin and unpin go through load, the hit-scan state,
// the simple state and the result state. A single scan pointer walks the
// buffer state, so the passes run one after another.
module hashed_block_buffer_cache
  import hbc_pkg::*;
#(
  parameter int unsigned BUFFER_COUNT = 32,
  parameter int unsigned BUCKET_COUNT = 13
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // The controller sequences the scans; the datapath holds all buffer state.
  hbc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  hbc_dp #(
    .BUFFER_COUNT (BUFFER_COUNT),
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[rtl/core/hbc_ctrl.sv]
module hbc_ctrl
  import hbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_HIT_SCAN;
      end
      ST_HIT_SCAN: begin
        if (!sts.is_get) state_nxt = ST_SIMPLE;
        else if (sts.scan_last) state_nxt = ST_HIT_DONE;
      end
      ST_HIT_DONE: begin
        if (sts.hit_found) state_nxt = ST_RESULT;
        else state_nxt = ST_VIC_SCAN;
      end
      ST_VIC_SCAN: begin
        if (sts.scan_last) state_nxt = ST_VIC_DONE;
      end
      ST_VIC_DONE: begin
        if (sts.vic_found || sts.last_bkt) state_nxt = ST_RESULT;
        else state_nxt = ST_VIC_SCAN;
      end
      ST_SIMPLE: state_nxt = ST_RESULT;
      ST_RESULT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:     cmd.load = start;
      ST_HIT_SCAN: cmd.scan_hit = sts.is_get;
      ST_HIT_DONE: cmd.do_hit = sts.hit_found;
      ST_VIC_SCAN: cmd.scan_vic = 1'b1;
      ST_VIC_DONE: begin
        cmd.do_vic = sts.vic_found;
        cmd.do_fail = !sts.vic_found && sts.last_bkt;
        cmd.next_bkt = !sts.vic_found && !sts.last_bkt;
      end
      ST_SIMPLE:   cmd.do_simple = 1'b1;
      ST_RESULT:   cmd.emit = 1'b1;
      default:     cmd = '0;
    endcase
  end

  `include "hashed_block_buffer_cache_macros.svh"

  `HBC_ASSERT_NEXT(a_result_to_idle, clk, rst_n, state_r == ST_RESULT, state_r == ST_IDLE, "result not followed by idle")
  `HBC_ASSERT_IMP(a_busy_no_load, clk, rst_n, busy, !cmd.load, "load while busy")
  `HBC_ASSERT_IMP(a_one_commit, clk, rst_n, 1'b1, $onehot0({cmd.do_hit, cmd.do_vic, cmd.do_fail, cmd.do_simple}), "several commits at once")

endmodule

[rtl/core/hbc_dp.sv]
module hbc_dp
  import hbc_pkg::*;
#(
  parameter int unsigned BUFFER_COUNT = 32,
  parameter int unsigned BUCKET_COUNT = 13
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  ctl_cmd_t  cmd,
  output ctl_sts_t  sts,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int unsigned PtrW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  // Reciprocal of the bucket count, scaled so that the quotient is exact for
  // every block number that fits in BlkW bits.
  localparam int unsigned RecipK = $clog2(BUCKET_COUNT);
  localparam longint unsigned RecipM =
    ((64'd1 << (BlkW + RecipK)) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);

  // Per-buffer state; small enough to sit in flip-flops read at the scan pointer.
  logic [DevW-1:0]  tag_dev_r  [BUFFER_COUNT];
  logic [BlkW-1:0]  tag_blk_r  [BUFFER_COUNT];
  logic [CntW-1:0]  ref_cnt_r  [BUFFER_COUNT];
  logic             valid_r    [BUFFER_COUNT];
  logic [TimeW-1:0] rel_time_r [BUFFER_COUNT];
  logic [BktW-1:0]  bkt_r      [BUFFER_COUNT];
  logic [31:0]      ins_r      [BUFFER_COUNT];
  logic [31:0]      next_ins_r;

  in_item_t        item_r;
  logic [BktW-1:0] home_r;     // home bucket
  logic [BktW-1:0] cur_bkt_r;  // bucket searched for a victim
  logic [BktW-1:0] bkt_left_r;
  logic [PtrW-1:0] ptr_r;
  logic            best_ok_r;
  logic [PtrW-1:0] best_r;
  logic [TimeW-1:0] best_time_r;
  logic [31:0]     best_age_r;
  logic            out_valid_r;
  out_item_t       out_r;

  // Home bucket: the quotient comes from one multiply by the scaled
  // reciprocal, and only the low bits of the quotient are then needed.
  logic [31:0]      recip;
  logic [BlkW+31:0] prod;
  logic [BktW-1:0]  quot_lo;
  logic [BktW-1:0]  home_calc;
  assign recip     = 32'(RecipM);
  assign prod      = (BlkW+32)'(in_item.block_number) * (BlkW+32)'(recip);
  assign quot_lo   = prod[BlkW+RecipK +: BktW];
  assign home_calc = in_item.block_number[BktW-1:0] - quot_lo * BktW'(BUCKET_COUNT);

  logic [31:0] age_c;
  logic        hit_c, vic_c, better_c;
  logic [PtrW-1:0] idx;
  assign idx   = PtrW'(item_r.buffer_index);
  assign age_c = next_ins_r - ins_r[ptr_r];
  assign hit_c = (bkt_r[ptr_r] == home_r) && (tag_dev_r[ptr_r] == item_r.device)
                 && (tag_blk_r[ptr_r] == item_r.block_number);
  assign vic_c = (bkt_r[ptr_r] == cur_bkt_r) && (ref_cnt_r[ptr_r] == '0);
  assign better_c = !best_ok_r || (rel_time_r[ptr_r] < best_time_r)
                    || ((rel_time_r[ptr_r] == best_time_r) && (age_c < best_age_r));

  logic idx_ok;
  assign idx_ok = (32'(item_r.buffer_index) < BUFFER_COUNT);

  always_comb begin
    sts.is_get    = (item_r.cmd == CMD_GET);
    sts.scan_last = (32'(ptr_r) == BUFFER_COUNT - 1);
    sts.hit_found = best_ok_r;
    sts.vic_found = best_ok_r;
    sts.last_bkt  = (bkt_left_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BUFFER_COUNT; k++) begin
        tag_dev_r[k]  <= '0;
        tag_blk_r[k]  <= '0;
        ref_cnt_r[k]  <= '0;
        valid_r[k]    <= 1'b0;
        rel_time_r[k] <= '0;
        bkt_r[k]      <= '0;
        ins_r[k]      <= 32'(k);
      end
      next_ins_r  <= 32'(BUFFER_COUNT);
      out_valid_r <= 1'b0;
      best_ok_r   <= 1'b0;
      ptr_r       <= '0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        item_r     <= in_item;
        home_r     <= home_calc;
        cur_bkt_r  <= home_calc;
        bkt_left_r <= BktW'(BUCKET_COUNT - 1);
        ptr_r      <= '0;
        best_ok_r  <= 1'b0;
        out_r      <= '0;
      end
      if (cmd.scan_hit || cmd.scan_vic) begin
        ptr_r <= sts.scan_last ? '0 : ptr_r + 1'b1;
        if (cmd.scan_hit && hit_c && (!best_ok_r || age_c < best_age_r)) begin
          best_ok_r <= 1'b1; best_r <= ptr_r; best_age_r <= age_c;
        end
        if (cmd.scan_vic && vic_c && better_c) begin
          best_ok_r <= 1'b1; best_r <= ptr_r; best_age_r <= age_c;
          best_time_r <= rel_time_r[ptr_r];
        end
      end
      if (cmd.next_bkt) begin
        bkt_left_r <= bkt_left_r - 1'b1;
        cur_bkt_r  <= (32'(cur_bkt_r) == BUCKET_COUNT - 1) ? '0 : cur_bkt_r + 1'b1;
      end
      if (cmd.do_hit) begin
        if (ref_cnt_r[best_r] != '1) ref_cnt_r[best_r] <= ref_cnt_r[best_r] + 1'b1;
        valid_r[best_r] <= 1'b1;
        out_r <= '{granted_buffer: IdxW'(best_r), was_hit: 1'b1,
                   needs_read: !valid_r[best_r], status: 1'b0};
      end
      if (cmd.do_vic) begin
        tag_dev_r[best_r] <= item_r.device;
        tag_blk_r[best_r] <= item_r.block_number;
        ref_cnt_r[best_r] <= CntW'(1);
        valid_r[best_r]   <= 1'b1;
        if (cur_bkt_r != home_r) begin
          bkt_r[best_r] <= home_r;
          ins_r[best_r] <= next_ins_r;
          next_ins_r    <= next_ins_r + 1'b1;
        end
        out_r <= '{granted_buffer: IdxW'(best_r), was_hit: 1'b0,
                   needs_read: 1'b1, status: 1'b0};
      end
      if (cmd.do_fail) begin
        out_r <= '{granted_buffer: '0, was_hit: 1'b0, needs_read: 1'b0, status: 1'b1};
      end
      if (cmd.do_simple && idx_ok) begin
        case (item_r.cmd)
          CMD_REL: begin
            if (ref_cnt_r[idx] != '0) begin
              ref_cnt_r[idx] <= ref_cnt_r[idx] - 1'b1;
              if (ref_cnt_r[idx] == CntW'(1)) rel_time_r[idx] <= item_r.now_ticks;
            end
          end
          CMD_PIN: if (ref_cnt_r[idx] != '1) ref_cnt_r[idx] <= ref_cnt_r[idx] + 1'b1;
          CMD_UNPIN: if (ref_cnt_r[idx] != '0) ref_cnt_r[idx] <= ref_cnt_r[idx] - 1'b1;
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `include "hashed_block_buffer_cache_macros.svh"

  `HBC_ASSERT_IMP(a_hit_tag, clk, rst_n, cmd.do_hit, tag_blk_r[best_r] == item_r.block_number, "hit without matching tag")
  `HBC_ASSERT_IMP(a_vic_free, clk, rst_n, cmd.do_vic, ref_cnt_r[best_r] == '0, "victim is referenced")
  `HBC_ASSERT_NEXT(a_fail_status, clk, rst_n, cmd.do_fail, out_r.status, "failed get not flagged")

endmodule

[tb/hashed_block_buffer_cache_tb.sv]
module hashed_block_buffer_cache_tb;
  import hbc_pkg::*;

  localparam int unsigned NBUF = 32;
  localparam int unsigned NBKT = 13;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned SETTLE = 600;
  localparam int unsigned RANDOM_ITEMS = 70;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  hashed_block_buffer_cache #(.BUFFER_COUNT(NBUF), .BUCKET_COUNT(NBKT)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item)
  );

  always #2 clk = ~clk;

  // The testbench's own copy of the buffer pool.
  logic [DevW-1:0]  pool_dev   [NBUF];
  logic [BlkW-1:0]  pool_blk   [NBUF];
  logic [CntW-1:0]  pool_refs  [NBUF];
  logic             pool_valid [NBUF];
  logic [TimeW-1:0] pool_rtime [NBUF];
  logic [BktW-1:0]  pool_bkt   [NBUF];
  logic [31:0]      pool_stamp [NBUF];
  logic [31:0]      stamp_next;

  in_item_t  pending_items[$];
  out_item_t awaited_results[$];
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  bit stimulus_done = 1'b0;

  // Every buffer starts in bucket 0, stamped by its index.
  task automatic pool_reset();
    for (int k = 0; k < NBUF; k++) begin
      pool_dev[k] = '0; pool_blk[k] = '0; pool_refs[k] = '0; pool_valid[k] = 1'b0;
      pool_rtime[k] = '0; pool_bkt[k] = '0; pool_stamp[k] = k;
    end
    stamp_next = NBUF;
  endtask

  // Least recently released free buffer in a bucket; ties go to the newest member.
  function automatic int pick_victim(int unsigned bkt);
    int best;
    best = -1;
    for (int k = 0; k < NBUF; k++) begin
      if (pool_bkt[k] != bkt || pool_refs[k] != 0) continue;
      if (best < 0 || pool_rtime[k] < pool_rtime[best] ||
          (pool_rtime[k] == pool_rtime[best] &&
           (stamp_next - pool_stamp[k]) < (stamp_next - pool_stamp[best])))
        best = k;
    end
    return best;
  endfunction

  // Applies one transaction to the pool and returns the result it must give.
  function automatic out_item_t cache_apply(in_item_t it);
    out_item_t r;
    int k;
    int unsigned h;
    r = '0;
    k = -1;
    if (cmd_t'(it.cmd) == CMD_GET) begin
      h = it.block_number % NBKT;
      for (int j = 0; j < NBUF; j++)
        if (pool_bkt[j] == h && pool_dev[j] == it.device && pool_blk[j] == it.block_number)
          if (k < 0 || (stamp_next - pool_stamp[j]) < (stamp_next - pool_stamp[k])) k = j;
      if (k >= 0) begin
        if (pool_refs[k] != 8'hFF) pool_refs[k]++;
        r.was_hit = 1'b1;
      end else begin
        k = pick_victim(h);
        if (k < 0) begin
          for (int d = 1; d < NBKT && k < 0; d++) k = pick_victim((h + d) % NBKT);
          if (k < 0) begin
            r.status = 1'b1;
            return r;
          end
          pool_bkt[k] = BktW'(h);
          pool_stamp[k] = stamp_next;
          stamp_next++;
        end
        pool_dev[k] = it.device;
        pool_blk[k] = it.block_number;
        pool_refs[k] = 8'd1;
        pool_valid[k] = 1'b0;
      end
      r.needs_read = !pool_valid[k];
      pool_valid[k] = 1'b1;
      r.granted_buffer = k[IdxW-1:0];
      return r;
    end
    k = int'(it.buffer_index);
    if (k >= NBUF) return r;
    case (cmd_t'(it.cmd))
      CMD_REL: begin
        if (pool_refs[k] != 0) begin
          pool_refs[k]--;
          if (pool_refs[k] == 0) pool_rtime[k] = it.now_ticks;
        end
      end
      CMD_PIN: if (pool_refs[k] != 8'hFF) pool_refs[k]++;
      default: if (pool_refs[k] != 0) pool_refs[k]--;
    endcase
    return r;
  endfunction

  // Block numbers come from a small working set so that hits and evictions are common.
  function automatic in_item_t make_item(cmd_t c, int unsigned dev, int unsigned blk,
                                         int unsigned idx, logic [TimeW-1:0] now);
    in_item_t it;
    it.cmd = c; it.device = DevW'(dev); it.block_number = BlkW'(blk);
    it.buffer_index = IdxW'(idx); it.now_ticks = now;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned sel;
    it.device = DevW'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(2));
    it.block_number = BlkW'($urandom_range(7) == 0 ? $urandom : $urandom_range(40));
    it.buffer_index = IdxW'($urandom_range(31));
    it.now_ticks = $urandom_range(3) == 0 ? $urandom : $urandom_range(20);
    sel = $urandom_range(99);
    if (sel < 40) it.cmd = CMD_GET;
    else if (sel < 75) it.cmd = CMD_REL;
    else if (sel < 85) it.cmd = CMD_PIN;
    else it.cmd = CMD_UNPIN;
    return it;
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        awaited_results.push_back(cache_apply(in_item));
        void'(pending_items.pop_front());
      end
      if (start && busy) begin
        // Hold the transaction until the block takes it.
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items[0];
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(8);
          gap_left <= $urandom_range(1) ? $urandom_range(70) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      idle_cycles <= (out_valid || (start && !busy)) ? 0 : idle_cycles + 1;
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result with no transaction outstanding: %p", out_item);
          failures++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_item.granted_buffer !== exp_r.granted_buffer) begin
            $error("granted_buffer expected %0d got %0d", exp_r.granted_buffer,
                   out_item.granted_buffer);
            failures++;
          end
          if (out_item.was_hit !== exp_r.was_hit) begin
            $error("was_hit expected %0b got %0b", exp_r.was_hit, out_item.was_hit);
            failures++;
          end
          if (out_item.needs_read !== exp_r.needs_read) begin
            $error("needs_read expected %0b got %0b", exp_r.needs_read, out_item.needs_read);
            failures++;
          end
          if (out_item.status !== exp_r.status) begin
            $error("status expected %0b got %0b", exp_r.status, out_item.status);
            failures++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction in either direction.
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("hashed_block_buffer_cache_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned pool_left;
    pool_reset();
    // Directed: field extremes, every command, the special cases.
    pending_items.push_back(make_item(CMD_GET, 255, 32'h7FFFFFFF, 0, 0));
    pending_items.push_back(make_item(CMD_GET, 255, 32'h7FFFFFFF, 0, 0));  // hit
    pending_items.push_back(make_item(CMD_GET, 0, 0, 31, 32'hFFFFFFFF));
    pending_items.push_back(make_item(CMD_REL, 0, 0, 31, 32'hFFFFFFFF));
    pending_items.push_back(make_item(CMD_REL, 0, 0, 5, 7));   // release at count zero
    pending_items.push_back(make_item(CMD_UNPIN, 0, 0, 6, 0)); // unpin at count zero
    pending_items.push_back(make_item(CMD_PIN, 0, 0, 3, 0));
    pending_items.push_back(make_item(CMD_UNPIN, 255, 32'h7FFFFFFF, 3, 0));
    for (int i = 0; i < 256; i++) pending_items.push_back(make_item(CMD_PIN, 0, 0, 9, 0));
    pending_items.push_back(make_item(CMD_REL, 0, 0, 9, 3));
    // Exhaust the pool with distinct blocks, then one more get finds nothing free.
    for (int i = 0; i < NBUF; i++) pending_items.push_back(make_item(CMD_GET, 1, 100 + i, 0, 0));
    pending_items.push_back(make_item(CMD_GET, 2, 500, 0, 0));
    for (int i = 0; i < NBUF; i++) pending_items.push_back(make_item(CMD_REL, 0, 0, i, 50 - i));
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_items.push_back(random_item());

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || start) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (failures == 0) begin
      $display("hashed_block_buffer_cache_tb OK");
    end else begin
      $display("hashed_block_buffer_cache_tb NOT OK");
    end
    $finish;
  end

endmodule
